// ----- design/positional_list_engine_assert.svh -----
// Assertion macros shared by the positional list engine RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define PLE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ple_pkg.sv -----
// Shared types and constants of the positional list engine.
// No dependencies; imported by the top level.
package ple_pkg;

	// Field widths of the stream items
	localparam int OP_W        = 3;
	localparam int POS_W       = 7;
	localparam int VAL_W       = 32;
	localparam int STAT_W      = 2;
	localparam int CNT_OUT_W   = 7;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// Default configuration
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND     = 3'd0,
		OP_POP_BACK   = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT_AT  = 3'd4,
		OP_ERASE_AT   = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage

// ----- design/ple_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the element store of the list engine.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/positional_list_engine.sv -----
// Positional list engine top level: ordered store of up to CAPACITY elements.
// Depends on ple_pkg, ple_ram and positional_list_engine_assert.svh.
//
// Elements sit packed in order in one RAM (one write, one registered read per
// cycle). Each input transfer yields exactly one output transfer. Clear, the
// unused opcode and every rejected operation go straight to the result stage;
// an insert at the end (push back, or insert at the count) only writes the value
// in the shift stage; any other insert or removal reads n = count - position
// entries through the RAM port pair, one entry per cycle, so at most CAPACITY
// entries. The single RAM port pair sets that rate. The next item is taken as
// soon as the previous result sits in the output register.
`include "positional_list_engine_assert.svh"

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] operation, [9:3] position, [41:10] value, [47:42] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] removed_value, [33:32] status, [40:34] element_count, [47:41] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int PAD_W = OUT_TDATA_W - (VAL_W + STAT_W + CNT_OUT_W);

	// Control state
	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_left_q;
	logic                  rd_v_s1;
	logic                  m_valid_q;

	// Operation payload
	logic                  mode_ins_q;
	logic                  first_q;
	logic [AW-1:0]         at_q;
	logic [AW-1:0]         rd_addr_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0]         rd_dst_s1;
	logic                  rd_cap_s1;
	logic [VAL_W-1:0]      res_removed_q;
	status_t               res_status_q;
	logic [VAL_W-1:0]      m_removed_q;
	status_t               m_status_q;
	logic [CNT_OUT_W-1:0]  m_count_q;

	// Input field unpack
	op_t               in_op;
	logic [POS_W-1:0]  in_pos;
	logic [VAL_W-1:0]  in_val;
	logic              in_xfer;

	assign in_op   = op_t'(s_axis_tdata[OP_W-1:0]);
	assign in_pos  = s_axis_tdata[OP_W+POS_W-1:OP_W];
	assign in_val  = s_axis_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// Decode of the accepted operation against the current count
	logic          is_full;
	logic          is_empty;
	logic          dec_ins;
	logic          dec_rem;
	logic          dec_clear;
	status_t       dec_status;
	logic [AW-1:0] dec_at;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		dec_ins    = 1'b0;
		dec_rem    = 1'b0;
		dec_clear  = 1'b0;
		dec_status = ST_DONE;
		dec_at     = '0;
		case (in_op)
			OP_APPEND: begin
				if (is_full) dec_status = ST_FULL;
				else begin
					dec_ins = 1'b1;
					dec_at  = AW'(count_q);
				end
			end
			OP_POP_BACK: begin
				if (is_empty) dec_status = ST_RANGE;
				else begin
					dec_rem = 1'b1;
					dec_at  = AW'(count_q - CNT_W'(1));
				end
			end
			OP_PUSH_FRONT: begin
				if (is_full) dec_status = ST_FULL;
				else dec_ins = 1'b1;
			end
			OP_POP_FRONT: begin
				if (is_empty) dec_status = ST_RANGE;
				else dec_rem = 1'b1;
			end
			OP_INSERT_AT: begin
				if (CMP_W'(in_pos) > CMP_W'(count_q)) dec_status = ST_RANGE;
				else if (is_full) dec_status = ST_FULL;
				else begin
					dec_ins = 1'b1;
					dec_at  = AW'(in_pos);
				end
			end
			OP_ERASE_AT: begin
				if (CMP_W'(in_pos) >= CMP_W'(count_q)) dec_status = ST_RANGE;
				else begin
					dec_rem = 1'b1;
					dec_at  = AW'(in_pos);
				end
			end
			OP_CLEAR: dec_clear = 1'b1;
			default: ;
		endcase
	end

	// RAM access: writes follow their reads in the next cycle
	logic                  rd_en;
	logic                  run_end;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] mem_rdata;
	logic                  out_free;

	assign rd_en     = (state_q == S_RUN) && (rd_left_q != '0);
	assign run_end   = (state_q == S_RUN) && (rd_left_q == '0) && !rd_v_s1;
	assign mem_we    = (state_q == S_RUN) &&
		((rd_v_s1 && !rd_cap_s1) || (run_end && mode_ins_q));
	assign mem_waddr = rd_v_s1 ? rd_dst_s1 : at_q;
	assign mem_wdata = rd_v_s1 ? mem_rdata : val_q;
	assign out_free  = !m_valid_q || m_axis_tready;

	ple_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	// Sequencer, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_left_q <= '0;
			rd_v_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (m_valid_q && m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (dec_ins || dec_rem) begin
							rd_left_q <= count_q - CNT_W'(dec_at);
							state_q   <= S_RUN;
						end else begin
							if (dec_clear) count_q <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_RUN: begin
					if (rd_en) rd_left_q <= rd_left_q - CNT_W'(1);
					if (run_end) begin
						count_q <= mode_ins_q ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operation and result payload
	always_ff @(posedge clk) begin
		rd_cap_s1 <= rd_en && first_q;
		rd_dst_s1 <= mode_ins_q ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
		if (state_q == S_IDLE && in_xfer) begin
			mode_ins_q    <= dec_ins;
			first_q       <= dec_rem;
			at_q          <= dec_at;
			val_q         <= DATA_WIDTH'(in_val);
			rd_addr_q     <= dec_ins ? AW'(count_q - CNT_W'(1)) : dec_at;
			res_removed_q <= '0;
			res_status_q  <= dec_status;
		end
		if (rd_en) begin
			rd_addr_q <= mode_ins_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
			first_q   <= 1'b0;
		end
		// First read of a removal is the removed element
		if (state_q == S_RUN && rd_v_s1 && rd_cap_s1) begin
			res_removed_q <= VAL_W'(mem_rdata);
		end
		if (state_q == S_DONE && out_free) begin
			m_removed_q <= res_removed_q;
			m_status_q  <= res_status_q;
			m_count_q   <= CNT_OUT_W'(count_q);
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, m_count_q, m_status_q, m_removed_q};

	// Checks
	`PLE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY),
		"element count above capacity")
	`PLE_ASSERT_SAME(a_no_rw_collision, mem_we && rd_en, mem_waddr != rd_addr_q,
		"RAM read and write hit the same entry")
	`PLE_ASSERT_SAME(a_full_count, m_valid_q && m_status_q == ST_FULL,
		m_count_q == CNT_OUT_W'(CAPACITY), "full status with store not full")
	`PLE_ASSERT_NEXT(a_run_ends_done, run_end, state_q == S_DONE,
		"shift pass did not hand over to the result stage")

endmodule
